// ===== rtl/core/lcgscd_pkg.sv =====
package lcgscd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 32;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned AddrW = 3;

  localparam logic [WordW-1:0] LcgMul = 32'd1103515245;
  localparam logic [WordW-1:0] LcgAdd = 32'h0000_3039;
  localparam logic [PhaseW-1:0] PhaseReload = 3'd4;
  localparam logic [PhaseW-1:0] PhaseStart = 3'd1;
  localparam logic [ByteW-1:0] ChainReset = 8'hFF;

  // register word index (paddr[2])
  localparam logic RegStreamSeed = 1'b0;

  localparam logic [WordW-1:0] SaltWords [64] = '{
    32'h1E0D8064, 32'h16EFF6E2, 32'h3A29FF98, 32'hAD28CF5E, 32'hCEFC4584, 32'hACE3AB65,
    32'h924997EB, 32'hF7A813C3, 32'hDED07CDD, 32'hEC7278F8, 32'h2B9412A5, 32'h909A5339,
    32'h99AE3F04, 32'hC1BF7532, 32'hFEDB9102, 32'hF0B5D67D, 32'hB6B33C3D, 32'hA276BC00,
    32'h8550E19C, 32'h2D664A09, 32'h79D56AB7, 32'hD11B3EEA, 32'h95717BA3, 32'h8B87B259,
    32'h18819F5C, 32'h934BCB27, 32'hBD6B2A11, 32'h19F5C8A0, 32'h40C21FF2, 32'hDA03DF6C,
    32'h82B15521, 32'hE6778963, 32'h2473C9A9, 32'h37E4D9C6, 32'h68F44F17, 32'hAF8607C7,
    32'hDCB8A6FA, 32'h8E470A88, 32'h831A14E7, 32'h7F359E74, 32'hA1E052FD, 32'h330B4C41,
    32'hBBF38F44, 32'h0C7A5808, 32'h9BE53BF1, 32'hC05DD426, 32'h60A77EF9, 32'h342551E8,
    32'h5A4D0FD7, 32'hC41D36D3, 32'h62202F8A, 32'h8D61AAB0, 32'h4801698C, 32'h6ED8ED38,
    32'h2E05CC42, 32'h065B1022, 32'h0E46234E, 32'hEE5FE9BA, 32'hA430B4B9, 32'h571CBE54,
    32'h9D96FBCD, 32'h70C56731, 32'h566D4315, 32'hCA6FD22C
  };

  typedef struct packed {
    logic [ByteW-1:0] key_byte;
    logic [ByteW-1:0] chain_byte;
  } ks_out_t;

  // salt table read as little-endian bytes
  function automatic logic [ByteW-1:0] salt_byte(input logic [ByteW-1:0] idx);
    logic [WordW-1:0] w;
    w = SaltWords[idx[7:2]];
    return w[8*idx[1:0] +: 8];
  endfunction

endpackage

// ===== rtl/core/lcgscd_cfg.sv =====
module lcgscd_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lcgscd_pkg::AddrW-1:0]     paddr,
  input  logic [lcgscd_pkg::WordW-1:0]     pwdata,
  output logic [lcgscd_pkg::WordW-1:0]     prdata,
  output logic                             pready,
  output logic [lcgscd_pkg::WordW-1:0]     seed
);

  logic [lcgscd_pkg::WordW-1:0] seed_r;
  logic                         wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (wr_en && paddr[2] == lcgscd_pkg::RegStreamSeed) begin
      seed_r <= pwdata;
    end
  end

  always_comb begin
    unique case (paddr[2])
      lcgscd_pkg::RegStreamSeed: prdata = seed_r;
      default:                   prdata = '0;
    endcase
  end

  assign seed = seed_r;

endmodule

// ===== rtl/core/lcgscd_keystream.sv =====
module lcgscd_keystream (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          stream_start,
  input  logic [lcgscd_pkg::ByteW-1:0]  cipher_byte,
  input  logic [lcgscd_pkg::WordW-1:0]  seed,
  output lcgscd_pkg::ks_out_t           ks
);

  logic [lcgscd_pkg::WordW-1:0]  gen_r, gen_nxt, gen_base;
  logic [lcgscd_pkg::WordW-1:0]  key_r, key_nxt, key_base;
  logic [lcgscd_pkg::PhaseW-1:0] phase_r, phase_nxt, phase_base, phase_dec;
  logic [lcgscd_pkg::ByteW-1:0]  chain_r, chain_base;
  logic                          wrap;

  always_comb begin
    // stream start reloads everything ahead of this byte
    gen_base   = stream_start ? seed : gen_r;
    key_base   = stream_start ? '0 : key_r;
    phase_base = stream_start ? lcgscd_pkg::PhaseStart : phase_r;
    chain_base = stream_start ? ~seed[lcgscd_pkg::ByteW-1:0] : chain_r;

    phase_dec = phase_base - 3'd1;
    wrap      = (phase_dec == '0);

    if (wrap) begin
      gen_nxt   = 32'(gen_base * lcgscd_pkg::LcgMul) + lcgscd_pkg::LcgAdd;
      key_nxt   = gen_nxt;
      phase_nxt = lcgscd_pkg::PhaseReload;
    end else begin
      gen_nxt   = gen_base;
      key_nxt   = key_base >> 8;
      phase_nxt = phase_dec;
    end

    ks.key_byte   = key_nxt[lcgscd_pkg::ByteW-1:0];
    ks.chain_byte = chain_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r   <= '0;
      key_r   <= '0;
      phase_r <= lcgscd_pkg::PhaseStart;
      chain_r <= lcgscd_pkg::ChainReset;
    end else if (step) begin
      gen_r   <= gen_nxt;
      key_r   <= key_nxt;
      phase_r <= phase_nxt;
      chain_r <= cipher_byte;
    end
  end

endmodule

// ===== rtl/core/lcg_salt_chained_byte_decrypt_unit.sv =====
// Path: an accepted input beat passes the input register, then the result register;
//   a beat waits in either one only while out_stall holds the result.
// Throughput: one beat per cycle while out_stall is low; the 32x32 generator multiply,
//   taken on every fourth byte, and the salt lookup both sit between the two registers.
// Reset (rst_n, synchronous, active low): empties both registers, clears the seed
//   and generator to 0, key word to 0, phase to 1 and the chain byte to 0xFF.
module lcg_salt_chained_byte_decrypt_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lcgscd_pkg::ByteW-1:0]  in_cipher_byte,
  input  logic                          in_stream_start,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lcgscd_pkg::ByteW-1:0]  out_plain_byte,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lcgscd_pkg::AddrW-1:0]  paddr,
  input  logic [lcgscd_pkg::WordW-1:0]  pwdata,
  output logic [lcgscd_pkg::WordW-1:0]  prdata,
  output logic                          pready
);

  // input register: holds one beat until the result register can take it
  logic                         in_vld_r;
  logic [lcgscd_pkg::ByteW-1:0] cipher_r;
  logic                         start_r;

  // result register
  logic                         out_vld_r;
  logic [lcgscd_pkg::ByteW-1:0] plain_r, plain_nxt;

  logic                         adv;      // move the held beat into the result register
  logic                         in_take;
  logic [lcgscd_pkg::WordW-1:0] seed;
  lcgscd_pkg::ks_out_t          ks;

  lcgscd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .seed    (seed)
  );

  // Advance the generator state only when the held beat actually moves on.
  lcgscd_keystream u_ks (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (adv),
    .stream_start (start_r),
    .cipher_byte  (cipher_r),
    .seed         (seed),
    .ks           (ks)
  );

  // The result slot frees up either when it is empty or when its beat leaves now.
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  // Stall the source only while a beat sits here that cannot move on.
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  // Plain byte: salt entry picked by cipher xor chain, masked by the key byte.
  assign plain_nxt = lcgscd_pkg::salt_byte(cipher_r ^ ks.chain_byte) ^ ks.key_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  // payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      cipher_r <= in_cipher_byte;
      start_r  <= in_stream_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      plain_r <= plain_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_plain_byte = plain_r;

`ifndef SYNTHESIS
  a_adv_fills_out : assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("result register not filled after advance");

  a_stall_needs_item : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && out_vld_r && out_stall))
    else $error("input stalled without a blocked beat");

  a_empty_out_moves : assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !out_vld_r) |-> adv)
    else $error("held beat not moved into empty result register");

  a_out_drop_needs_take : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall && !adv) |=> out_vld_r)
    else $error("result beat lost while stalled");
`endif

endmodule
